// ----- sv/hors_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hors_pkg
// Shared types and constants of the heap object reference scanner.
// ----------------------------------------------------------------------------
package hors_pkg;

	localparam int PATTERN_WORDS   = 8;
	localparam int SLOT_INDEX_BITS = 16;
	localparam int PAT_IDX_W       = (PATTERN_WORDS > 1) ? $clog2(PATTERN_WORDS) : 1;
	localparam int PCNT_W          = $clog2(PATTERN_WORDS + 1);
	localparam int Q_DEPTH         = 4;
	localparam int Q_PTR_W         = $clog2(Q_DEPTH);
	localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

	localparam logic [SLOT_INDEX_BITS-1:0] CNT_MAX = {SLOT_INDEX_BITS{1'b1}};

	localparam logic [1:0] OP_BEGIN   = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_SLOT    = 2'd2;
	localparam logic [1:0] OP_STOP    = 2'd3;

	localparam logic       KIND_SIZE = 1'b0;
	localparam logic       KIND_REF  = 1'b1;

	localparam logic [1:0] FMT_TRACEABLE = 2'd1;
	localparam logic [1:0] FMT_PATTERNED = 2'd2;

	localparam logic [2:0] VFMT_TRACED = 3'd2;
	localparam logic [2:0] VFMT_BYTE_A = 3'd4;
	localparam logic [2:0] VFMT_BYTE_B = 3'd5;
	localparam logic [2:0] VFMT_NONE   = 3'd7;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] header_word;
		logic [31:0] fixed_format_word;
		logic [31:0] vector_format_word;
		logic [31:0] size_slot_word;
		logic [31:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] reference_word;
		logic [15:0] slot_index;
		logic [31:0] object_size;
		logic        overflow;
	} out_item_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} qstat_t;

endpackage

// ----- sv/hors_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hors_front
// Accepts items, keeps the object state and bitmap, and classifies each item
// into a result or none.
// ----------------------------------------------------------------------------
module hors_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hors_pkg::in_item_t  in_item,
	output logic                push_valid,
	input  logic                push_ready,
	output hors_pkg::out_item_t push_item
);

	logic                                  obj_valid_q;
	logic                                  stopped_q;
	logic [1:0]                            fixed_mode_q;
	logic                                  vec_traced_q;
	logic [31:0]                           fixed_words_q;
	logic [31:0]                           vec_end_q;
	logic [hors_pkg::SLOT_INDEX_BITS-1:0]  slot_cnt_q;
	logic [hors_pkg::PCNT_W-1:0]           pat_cnt_q;
	logic [31:0]                           size_q;
	logic [31:0]                           pat_mem_q [hors_pkg::PATTERN_WORDS];

	logic                                  accept;
	logic                                  hdr_ok;
	logic [2:0]                            vform;
	logic [31:0]                           f_words;
	logic [31:0]                           rep;
	logic [31:0]                           var_part;
	logic [31:0]                           size_new;
	logic [31:0]                           vend_new;
	logic [31:0]                           idx32;
	logic [hors_pkg::SLOT_INDEX_BITS-1:0]  bit_idx;
	logic [31:0]                           w32;
	logic [31:0]                           pat_word;
	logic                                  can_slot;
	logic                                  pat_room;
	logic                                  emit;
	hors_pkg::out_item_t                   res;

	assign accept   = in_valid && push_ready;
	assign in_ready = push_ready;

	assign hdr_ok  = (in_item.header_word != 32'd0) && (in_item.header_word[1:0] == 2'b00);
	assign vform   = in_item.vector_format_word[2:0];
	assign f_words = {2'b00, in_item.fixed_format_word[31:2]} + 32'd1;
	assign rep     = {{2{in_item.size_slot_word[31]}}, in_item.size_slot_word[31:2]};

	always_comb begin
		priority if (vform == hors_pkg::VFMT_NONE) begin
			var_part = 32'd0;
		end else if (vform == hors_pkg::VFMT_BYTE_A || vform == hors_pkg::VFMT_BYTE_B) begin
			var_part = 32'd4 + rep;
		end else begin
			var_part = 32'd4 + {rep[29:0], 2'b00};
		end
	end

	assign size_new = {f_words[29:0], 2'b00} + var_part;
	assign vend_new = f_words + 32'd1 +
		(((vform == hors_pkg::VFMT_TRACED) && !in_item.size_slot_word[31]) ?
		{2'b00, in_item.size_slot_word[31:2]} : 32'd0);

	assign idx32    = 32'(slot_cnt_q);
	assign bit_idx  = slot_cnt_q - 1'b1;
	assign w32      = 32'(bit_idx[hors_pkg::SLOT_INDEX_BITS-1:5]);
	assign pat_word = pat_mem_q[w32[hors_pkg::PAT_IDX_W-1:0]];
	assign can_slot = obj_valid_q && !stopped_q && (slot_cnt_q != hors_pkg::CNT_MAX);
	assign pat_room = 32'(pat_cnt_q) < hors_pkg::PATTERN_WORDS;

	always_comb begin
		emit               = 1'b0;
		res.kind           = hors_pkg::KIND_REF;
		res.reference_word = in_item.data_word;
		res.slot_index     = idx32[15:0];
		res.object_size    = size_q;
		res.overflow       = 1'b0;
		unique case (in_item.opcode)
			hors_pkg::OP_BEGIN: begin
				emit               = 1'b1;
				res.kind           = hors_pkg::KIND_SIZE;
				res.reference_word = 32'd0;
				res.slot_index     = 16'd0;
				res.object_size    = hdr_ok ? size_new : 32'd0;
			end
			hors_pkg::OP_SLOT: begin
				if (can_slot) begin
					if (idx32 < fixed_words_q) begin
						if (fixed_mode_q == hors_pkg::FMT_TRACEABLE) begin
							emit = 1'b1;
						end else if (fixed_mode_q == hors_pkg::FMT_PATTERNED) begin
							if (w32 >= hors_pkg::PATTERN_WORDS) begin
								emit         = 1'b1;
								res.overflow = 1'b1;
							end else if (w32 < 32'(pat_cnt_q) && pat_word[bit_idx[4:0]]) begin
								emit = 1'b1;
							end
						end
					end else if (idx32 > fixed_words_q && vec_traced_q && idx32 < vec_end_q) begin
						emit = 1'b1;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push_valid = in_valid && emit;
	assign push_item  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_valid_q   <= 1'b0;
			stopped_q     <= 1'b1;
			fixed_mode_q  <= 2'd0;
			vec_traced_q  <= 1'b0;
			fixed_words_q <= 32'd0;
			vec_end_q     <= 32'd0;
			slot_cnt_q    <= '0;
			pat_cnt_q     <= '0;
			size_q        <= 32'd0;
		end else if (accept) begin
			unique case (in_item.opcode)
				hors_pkg::OP_BEGIN: begin
					pat_cnt_q  <= '0;
					slot_cnt_q <= {{(hors_pkg::SLOT_INDEX_BITS-1){1'b0}}, 1'b1};
					if (hdr_ok) begin
						obj_valid_q   <= 1'b1;
						stopped_q     <= 1'b0;
						fixed_mode_q  <= in_item.fixed_format_word[1:0];
						vec_traced_q  <= (vform == hors_pkg::VFMT_TRACED);
						fixed_words_q <= f_words;
						vec_end_q     <= vend_new;
						size_q        <= size_new;
					end else begin
						obj_valid_q   <= 1'b0;
						stopped_q     <= 1'b1;
						fixed_mode_q  <= 2'd0;
						vec_traced_q  <= 1'b0;
						fixed_words_q <= 32'd0;
						vec_end_q     <= 32'd0;
						size_q        <= 32'd0;
					end
				end
				hors_pkg::OP_PATTERN: begin
					if (pat_room) begin
						pat_cnt_q <= pat_cnt_q + 1'b1;
					end
				end
				hors_pkg::OP_SLOT: begin
					if (can_slot) begin
						slot_cnt_q <= slot_cnt_q + 1'b1;
					end
				end
				default: begin
					stopped_q <= 1'b1;
				end
			endcase
		end
	end

	// bitmap store, no reset
	always_ff @(posedge clk) begin
		if (accept && in_item.opcode == hors_pkg::OP_PATTERN && pat_room) begin
			pat_mem_q[pat_cnt_q[hors_pkg::PAT_IDX_W-1:0]] <= in_item.data_word;
		end
	end

endmodule

// ----- sv/hors_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hors_queue
// Short result queue between the classifying front and the output stage.
// ----------------------------------------------------------------------------
module hors_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  hors_pkg::out_item_t push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output hors_pkg::out_item_t pop_item,
	output hors_pkg::qstat_t    stat
);

	hors_pkg::out_item_t              mem_q [hors_pkg::Q_DEPTH];
	logic [hors_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [hors_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [hors_pkg::Q_CNT_W-1:0]     cnt_q;
	logic                             do_push;
	logic                             do_pop;

	assign stat.full  = (32'(cnt_q) == hors_pkg::Q_DEPTH);
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- sv/hors_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hors_back
// Output stage: takes results from the queue into the output register.
// ----------------------------------------------------------------------------
module hors_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  hors_pkg::out_item_t pop_item,
	output logic                out_valid,
	input  logic                out_ready,
	output hors_pkg::out_item_t out_item
);

	logic                out_valid_q;
	hors_pkg::out_item_t out_item_q;

	assign pop_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			out_item_q <= pop_item;
		end
	end

endmodule

// ----- sv/heap_object_reference_scanner_unit.sv -----
`timescale 1ns / 1ps
// Takes one item per clock while the result queue has room. A begin item
// always yields a size report; slot items yield a traced reference when the
// slot holds one; pattern and stop items yield nothing. A result passes
// from its accepted item through a four-entry queue into the output register,
// so input and output stall on their own. The slot classifier is combinational:
// one bitmap bit and a counter compare per slot.
// ----------------------------------------------------------------------------
// heap_object_reference_scanner_unit
// Top level: front classifier, result queue and output stage.
// ----------------------------------------------------------------------------
module heap_object_reference_scanner_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hors_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output hors_pkg::out_item_t out_item
);

	logic                push_valid;
	logic                push_ready;
	hors_pkg::out_item_t push_item;
	logic                pop_valid;
	logic                pop_ready;
	hors_pkg::out_item_t pop_item;
	hors_pkg::qstat_t    q_stat;

	hors_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	hors_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.stat       (q_stat)
	);

	hors_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	a_begin_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.opcode == hors_pkg::OP_BEGIN) |-> push_valid)
		else $error("begin item did not yield a size report");

	a_quiet_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && (in_item.opcode == hors_pkg::OP_PATTERN ||
		in_item.opcode == hors_pkg::OP_STOP)) |-> !push_valid)
		else $error("pattern or stop item yielded a result");

	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready && !(pop_valid && pop_ready)) |=>
		(q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("queue count lost a pushed item");

	a_size_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind == hors_pkg::KIND_SIZE) |->
		(out_item.reference_word == 32'd0 && out_item.slot_index == 16'd0 &&
		!out_item.overflow))
		else $error("size report carries reference fields");
`endif

endmodule
